[rtl/tscr_pkg.sv]
// Package for the top-two class similarity ranker.
// Holds widths, register and model codes and the cell payload type.
// No dependencies.
`default_nettype none

package tscr_pkg;

  localparam int FRACTION_BITS = 15;
  localparam int SIM_W         = 16;
  localparam int TAG_W         = 5;
  localparam int NUM_CLS       = 5;
  localparam int LANE_W        = 3;
  localparam int RANK_W        = 3;
  localparam int CLS_W         = 3;
  localparam int TERM_W        = FRACTION_BITS + 1;
  localparam int DIV_STEPS     = TERM_W;
  localparam int REM_W         = SIM_W + 1;
  localparam int IDX_W         = FRACTION_BITS + CLS_W;
  localparam int IDXV_W        = 18;
  localparam int CMP_W         = (SIM_W > TERM_W) ? SIM_W : TERM_W;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 2;
  localparam int NSTG          = DIV_STEPS + 3;

  localparam logic [TERM_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIND_SECOND   = 2'd0,
    REG_COMPUTE_INDEX = 2'd1,
    REG_INDEX_MODEL   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODEL_NONE          = 2'd0,
    MODEL_ONE_MINUS_F   = 2'd1,
    MODEL_ONE_MINUS_GAP = 2'd2,
    MODEL_RATIO         = 2'd3
  } model_e;

  typedef logic [SIM_W-1:0] sim_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic nodata;
    tag_t ftag;
    sim_t fsim;
    tag_t stag;
    sim_t ssim;
  } cell_t;

endpackage

`default_nettype wire

[rtl/tscr_lane.sv]
// One ranking lane: counts how many of the other classes outrank its own class.
// Depends on tscr_pkg.
`default_nettype none

module tscr_lane (
  input  tscr_pkg::sim_t                sims_i [tscr_pkg::NUM_CLS],
  input  logic [tscr_pkg::LANE_W-1:0]   lane_i,
  output logic [tscr_pkg::RANK_W-1:0]   rank_o
);
  import tscr_pkg::*;

  sim_t own_sim;

  assign own_sim = sims_i[lane_i];

  // A class with a larger tag sits at a higher lane and wins a tie.
  always_comb begin
    rank_o = '0;
    for (int j = 0; j < NUM_CLS; j++) begin
      if (LANE_W'(j) != lane_i &&
          (sims_i[j] > own_sim || (sims_i[j] == own_sim && LANE_W'(j) > lane_i))) begin
        rank_o = rank_o + RANK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tscr_merge.sv]
// Merging stage: picks the first and second class from the lane ranks.
// Depends on tscr_pkg.
`default_nettype none

module tscr_merge (
  input  tscr_pkg::sim_t              sims_i [tscr_pkg::NUM_CLS],
  input  logic [tscr_pkg::NUM_CLS-1:0] first_sel_i,
  input  logic [tscr_pkg::NUM_CLS-1:0] second_sel_i,
  input  logic                        nodata_i,
  output tscr_pkg::cell_t             cell_o
);
  import tscr_pkg::*;

  // The one-hot selects are the tags themselves.
  always_comb begin
    cell_o.nodata = nodata_i;
    cell_o.ftag   = first_sel_i;
    cell_o.stag   = second_sel_i;
    cell_o.fsim   = '0;
    cell_o.ssim   = '0;
    for (int k = 0; k < NUM_CLS; k++) begin
      cell_o.fsim = cell_o.fsim | (sims_i[k] & {SIM_W{first_sel_i[k]}});
      cell_o.ssim = cell_o.ssim | (sims_i[k] & {SIM_W{second_sel_i[k]}});
    end
  end

endmodule

`default_nettype wire

[rtl/tscr_div_step.sv]
// One registered step of the restoring divider for the ratio model.
// Produces one quotient bit per stage and carries the cell along. Depends on tscr_pkg.
`default_nettype none

module tscr_div_step (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  tscr_pkg::cell_t             cell_i,
  input  logic [tscr_pkg::REM_W-1:0]  rem_i,
  input  logic [tscr_pkg::TERM_W-1:0] quo_i,
  output tscr_pkg::cell_t             cell_o,
  output logic [tscr_pkg::REM_W-1:0]  rem_o,
  output logic [tscr_pkg::TERM_W-1:0] quo_o
);
  import tscr_pkg::*;

  logic [REM_W-1:0] div_ext;
  logic             bit_d;
  logic [REM_W-1:0] diff;
  logic [REM_W-1:0] rem_d;

  assign div_ext = REM_W'(cell_i.fsim);
  assign bit_d   = (rem_i >= div_ext);
  assign diff    = bit_d ? (rem_i - div_ext) : rem_i;
  // The remainder stays below the divisor, so doubling it fits.
  assign rem_d   = {diff[REM_W-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_i;
      rem_o  <= rem_d;
      quo_o  <= {quo_i[TERM_W-2:0], bit_d};
    end
  end

endmodule

`default_nettype wire

[rtl/top_two_class_similarity_ranker.sv]
// Top level of the top-two class similarity ranker: lanes, merge, divider and output stage.
// Depends on tscr_pkg, tscr_lane, tscr_merge and tscr_div_step.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o    | ridge_nodata_i, five *_sim_i similarities
//  out     | out_valid_o / out_ready_i  | cell_valid_o .. index_value_o
//  cfg     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One beat per cycle is accepted while in_ready_o is high; each beat passes through the
// lane, merge, divider and output registers in turn. The pipeline depth is set by the
// ratio-model divider, which resolves one quotient bit per pipeline stage.
// Reset clears the stage valid bits and both flags; the index model resets to ONE_MINUS_F.
// Each stage holds while the next one is full and stalled; empty stages still take beats.
`default_nettype none

module top_two_class_similarity_ranker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tscr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tscr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            ridge_nodata_i,
  input  logic [15:0]                     ridge_sim_i,
  input  logic [15:0]                     shoulder_sim_i,
  input  logic [15:0]                     back_sim_i,
  input  logic [15:0]                     foot_sim_i,
  input  logic [15:0]                     valley_sim_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            cell_valid_o,
  output logic [4:0]                      first_tag_o,
  output logic [15:0]                     first_similarity_o,
  output logic                            second_valid_o,
  output logic [4:0]                      second_tag_o,
  output logic [15:0]                     second_similarity_o,
  output logic                            index_valid_o,
  output logic [17:0]                     index_value_o
);
  import tscr_pkg::*;

  // Configuration
  logic       find_second_q;
  logic       compute_index_q;
  logic [1:0] index_model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_second_q   <= 1'b0;
      compute_index_q <= 1'b0;
      index_model_q   <= MODEL_ONE_MINUS_F;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIND_SECOND:   find_second_q   <= cfg_data_i[0];
        REG_COMPUTE_INDEX: compute_index_q <= cfg_data_i[0];
        REG_INDEX_MODEL:   index_model_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it or any later stage is empty, or the output is taken.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vin;

  always_comb begin
    logic [NSTG-1:0] lo_mask;
    for (int k = 0; k < NSTG; k++) begin
      lo_mask = NSTG'((64'd1 << k) - 64'd1);
      rdy[k]  = out_ready_i || !(&(vld_q | lo_mask));
    end
  end

  assign vin        = {vld_q[NSTG-2:0], in_valid_i};
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // Lane stage
  sim_t              in_sims [NUM_CLS];
  logic [RANK_W-1:0] lane_rank [NUM_CLS];
  sim_t              s0_sim_q [NUM_CLS];
  logic [NUM_CLS-1:0] s0_first_q;
  logic [NUM_CLS-1:0] s0_second_q;
  logic              s0_nodata_q;

  assign in_sims[0] = ridge_sim_i;
  assign in_sims[1] = shoulder_sim_i;
  assign in_sims[2] = back_sim_i;
  assign in_sims[3] = foot_sim_i;
  assign in_sims[4] = valley_sim_i;

  for (genvar g = 0; g < NUM_CLS; g++) begin : g_lane
    tscr_lane u_lane (
      .sims_i (in_sims),
      .lane_i (LANE_W'(g)),
      .rank_o (lane_rank[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_nodata_q <= ridge_nodata_i;
      for (int k = 0; k < NUM_CLS; k++) begin
        s0_sim_q[k]    <= in_sims[k];
        s0_first_q[k]  <= (lane_rank[k] == RANK_W'(0));
        s0_second_q[k] <= (lane_rank[k] == RANK_W'(1));
      end
    end
  end

  // Merge stage
  cell_t merge_cell;
  cell_t m_cell_q;

  tscr_merge u_merge (
    .sims_i       (s0_sim_q),
    .first_sel_i  (s0_first_q),
    .second_sel_i (s0_second_q),
    .nodata_i     (s0_nodata_q),
    .cell_o       (merge_cell)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      m_cell_q <= merge_cell;
    end
  end

  // Divider pipeline for the ratio model: second / first with FRACTION_BITS fraction bits.
  cell_t             div_cell [DIV_STEPS+1];
  logic [REM_W-1:0]  div_rem  [DIV_STEPS+1];
  logic [TERM_W-1:0] div_quo  [DIV_STEPS+1];

  assign div_cell[0] = m_cell_q;
  assign div_rem[0]  = REM_W'(m_cell_q.ssim);
  assign div_quo[0]  = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    tscr_div_step u_step (
      .clk_i  (clk_i),
      .en_i   (rdy[g+2]),
      .cell_i (div_cell[g]),
      .rem_i  (div_rem[g]),
      .quo_i  (div_quo[g]),
      .cell_o (div_cell[g+1]),
      .rem_o  (div_rem[g+1]),
      .quo_o  (div_quo[g+1])
    );
  end

  // Output stage
  cell_t             fin;
  logic [TERM_W-1:0] quo;
  logic [CMP_W-1:0]  f_ext;
  logic [CMP_W-1:0]  d_ext;
  logic [CMP_W-1:0]  one_ext;
  logic [TERM_W-1:0] term;
  logic [TERM_W-1:0] half;
  logic              idx_ok;
  logic [CLS_W-1:0]  cls;
  logic [IDX_W-1:0]  base;
  logic [IDX_W-1:0]  idx_full;

  logic              cell_valid_d,  cell_valid_q;
  tag_t              first_tag_d,   first_tag_q;
  sim_t              first_sim_d,   first_sim_q;
  logic              second_valid_d, second_valid_q;
  tag_t              second_tag_d,  second_tag_q;
  sim_t              second_sim_d,  second_sim_q;
  logic              index_valid_d, index_valid_q;
  logic [IDXV_W-1:0] index_value_d, index_value_q;

  assign fin     = div_cell[DIV_STEPS];
  assign quo     = div_quo[DIV_STEPS];
  assign f_ext   = CMP_W'(fin.fsim);
  assign d_ext   = CMP_W'(fin.fsim - fin.ssim);
  assign one_ext = CMP_W'(ONE);

  always_comb begin
    term   = '0;
    idx_ok = compute_index_q;
    case (index_model_q)
      MODEL_ONE_MINUS_F:   term = (f_ext >= one_ext) ? '0 : TERM_W'(one_ext - f_ext);
      MODEL_ONE_MINUS_GAP: term = (d_ext >= one_ext) ? '0 : TERM_W'(one_ext - d_ext);
      MODEL_RATIO: begin
        term = (quo > ONE) ? ONE : quo;
        if (fin.fsim == '0) begin
          idx_ok = 1'b0;
        end
      end
      default: idx_ok = 1'b0;
    endcase
    half = term >> 1;

    cls = '0;
    for (int k = 0; k < NUM_CLS; k++) begin
      if (fin.ftag[k]) begin
        cls = CLS_W'(k + 1);
      end
    end
    base     = IDX_W'(cls) << FRACTION_BITS;
    idx_full = (fin.stag > fin.ftag) ? (base + IDX_W'(half)) : (base - IDX_W'(half));
  end

  always_comb begin
    cell_valid_d   = 1'b0;
    first_tag_d    = '0;
    first_sim_d    = '0;
    second_valid_d = 1'b0;
    second_tag_d   = '0;
    second_sim_d   = '0;
    index_valid_d  = 1'b0;
    index_value_d  = '0;
    if (!fin.nodata) begin
      cell_valid_d = 1'b1;
      first_tag_d  = fin.ftag;
      first_sim_d  = fin.fsim;
      if (find_second_q) begin
        second_valid_d = 1'b1;
        second_tag_d   = fin.stag;
        second_sim_d   = fin.ssim;
        if (idx_ok) begin
          index_valid_d = 1'b1;
          index_value_d = IDXV_W'(idx_full);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1]) begin
      cell_valid_q   <= cell_valid_d;
      first_tag_q    <= first_tag_d;
      first_sim_q    <= first_sim_d;
      second_valid_q <= second_valid_d;
      second_tag_q   <= second_tag_d;
      second_sim_q   <= second_sim_d;
      index_valid_q  <= index_valid_d;
      index_value_q  <= index_value_d;
    end
  end

  assign out_valid_o         = vld_q[NSTG-1];
  assign cell_valid_o        = cell_valid_q;
  assign first_tag_o         = first_tag_q;
  assign first_similarity_o  = first_sim_q;
  assign second_valid_o      = second_valid_q;
  assign second_tag_o        = second_tag_q;
  assign second_similarity_o = second_sim_q;
  assign index_valid_o       = index_valid_q;
  assign index_value_o       = index_value_q;

`ifndef ASSERT_OFF
  // The input side only stalls when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&vld_q)))
    else $error("input stalled with room in the pipeline");

  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cell_valid_o) |-> $onehot(first_tag_o))
    else $error("first tag is not a single class");

  a_second_ranked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && second_valid_o) |->
      ($onehot(second_tag_o) && second_tag_o != first_tag_o &&
       second_similarity_o <= first_similarity_o))
    else $error("second rank inconsistent with first");

  a_index_needs_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_valid_o) |-> (second_valid_o && cell_valid_o))
    else $error("index reported without second rank");

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cell_valid_o) |->
      (first_tag_o == '0 && !second_valid_o && !index_valid_o))
    else $error("no-data cell carries data");
`endif

endmodule

`default_nettype wire
